### sv/nrbf_pkg.sv
// ----------------------------------------------------------------------------
// nrbf_pkg
// shared types, constants and saturating fixed-point helpers for the newton
// root basin finder
// ----------------------------------------------------------------------------
package nrbf_pkg;

   // command codes
   localparam logic CMD_ROOT_WRITE = 1'b0;
   localparam logic CMD_RUN        = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_ROOT_COUNT = 2'd0;
   localparam logic [1:0] CSR_TOLERANCE  = 2'd1;
   localparam logic [1:0] CSR_MAX_ITER   = 2'd2;

   // configuration reset values
   localparam logic [3:0]  ROOT_COUNT_RST = 4'd3;
   localparam logic [30:0] TOLERANCE_RST  = 31'd16777;
   localparam logic [9:0]  MAX_ITER_RST   = 10'd64;

   // q32.32 constants and q8.24 saturation limits
   localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
   localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic               cmd;
      logic [2:0]         root_index;
      logic signed [31:0] root_re;
      logic signed [31:0] root_im;
      logic signed [31:0] start_re;
      logic signed [31:0] start_im;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [2:0] root_number;
   } rsp_type;

   typedef struct packed {
      logic               go;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] res;
   } mul_rsp_type;

   typedef struct packed {
      logic               go;
      logic signed [63:0] num;
      logic signed [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] res;
   } div_rsp_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_PROD,
      MUL_SUM,
      MUL_RND
   } mul_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_STEP,
      DIV_END
   } div_state_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_TOL,
      ST_IT,
      ST_OUT,
      ST_IN,
      ST_WLD,
      ST_CMUL,
      ST_OEND,
      ST_DEN,
      ST_NUM,
      ST_DIVR,
      ST_DIVI,
      ST_CRD,
      ST_CLD,
      ST_CHK,
      ST_FIN
   } ctl_state_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return s[63:0];
   endfunction

   // signed result from sign and magnitude, saturating
   function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
      if (m[63]) return neg ? Q_MIN : Q_MAX;
      return neg ? -$signed(m) : $signed(m);
   endfunction

   // q32.32 back to q8.24, floor then saturate
   function automatic logic signed [31:0] to_q824(input logic signed [63:0] x);
      logic [55:0] f;
      f = x[63:8];
      if (f[55:31] != {25{f[55]}}) return f[55] ? C_MIN : C_MAX;
      return f[31:0];
   endfunction

endpackage

### sv/nrbf_qmul.sv
// ----------------------------------------------------------------------------
// nrbf_qmul
// multi-cycle q32.32 multiplier, one 32x32 partial product a cycle,
// round to nearest ties away from zero, saturating
// ----------------------------------------------------------------------------
module nrbf_qmul import nrbf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mreq,
   output mul_rsp_type mrsp
);

   mul_state_type state_ff, state_in;
   logic [1:0]    step_ff, step_in;
   logic          done_ff, done_in;
   logic [63:0]   ma_ff, ma_in, mb_ff, mb_in;
   logic          neg_ff, neg_in;
   logic [63:0]   p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic [63:0]   hi_ff, hi_in, lo_ff, lo_in;
   logic signed [63:0] res_ff, res_in;

   logic [31:0] ah, bh;
   logic [63:0] prod;
   logic [33:0] mid;
   logic [63:0] rnd;

   assign ah   = step_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign bh   = step_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
   assign prod = {32'd0, ah} * {32'd0, bh};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      neg_in   = neg_ff;
      p00_in   = p00_ff;
      p01_in   = p01_ff;
      p10_in   = p10_ff;
      p11_in   = p11_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      res_in   = res_ff;
      mid      = {2'd0, p00_ff[63:32]} + {2'd0, p01_ff[31:0]} + {2'd0, p10_ff[31:0]};
      rnd      = {hi_ff[31:0], lo_ff[63:32]};
      unique case (state_ff)
         MUL_IDLE: begin
            if (mreq.go) begin
               ma_in    = mreq.a[63] ? 64'(-mreq.a) : mreq.a;
               mb_in    = mreq.b[63] ? 64'(-mreq.b) : mreq.b;
               neg_in   = mreq.a[63] ^ mreq.b[63];
               step_in  = 2'd0;
               state_in = MUL_PROD;
            end
         end
         MUL_PROD: begin
            case (step_ff)
               2'd0:    p00_in = prod;
               2'd1:    p01_in = prod;
               2'd2:    p10_in = prod;
               default: p11_in = prod;
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) state_in = MUL_SUM;
         end
         MUL_SUM: begin
            lo_in    = {mid[31:0], p00_ff[31:0]};
            hi_in    = p11_ff + {32'd0, p01_ff[63:32]} + {32'd0, p10_ff[63:32]}
                       + {62'd0, mid[33:32]};
            state_in = MUL_RND;
         end
         MUL_RND: begin
            if (hi_ff[63:32] != 32'd0) rnd = '1;
            else if (lo_ff[31] && rnd != '1) rnd = rnd + 64'd1;
            res_in   = from_mag(neg_ff, rnd);
            done_in  = 1'b1;
            state_in = MUL_IDLE;
         end
         default: state_in = MUL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         step_ff  <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      p00_ff <= p00_in;
      p01_ff <= p01_in;
      p10_ff <= p10_in;
      p11_ff <= p11_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      res_ff <= res_in;
   end

   assign mrsp.done = done_ff;
   assign mrsp.res  = res_ff;

endmodule

### sv/nrbf_qdiv.sv
// ----------------------------------------------------------------------------
// nrbf_qdiv
// restoring q32.32 divider, one quotient bit a cycle, truncating, saturating
// ----------------------------------------------------------------------------
module nrbf_qdiv import nrbf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type dreq,
   output div_rsp_type drsp
);

   div_state_type state_ff, state_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [95:0]   sh_ff, sh_in;
   logic [63:0]   rem_ff, rem_in, q_ff, q_in, d_ff, d_in;
   logic          neg_ff, neg_in, ovf_ff, ovf_in;
   logic signed [63:0] res_ff, res_in;

   logic [63:0] n_mag, remx;

   assign n_mag = dreq.num[63] ? 64'(-dreq.num) : dreq.num;
   assign remx  = {rem_ff[62:0], sh_ff[95]};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      sh_in    = sh_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      d_in     = d_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      res_in   = res_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (dreq.go) begin
               sh_in    = {n_mag, 32'd0};
               d_in     = dreq.den;
               neg_in   = dreq.num[63];
               rem_in   = 64'd0;
               q_in     = 64'd0;
               ovf_in   = 1'b0;
               cnt_in   = 7'd95;
               state_in = DIV_STEP;
            end
         end
         DIV_STEP: begin
            sh_in  = {sh_ff[94:0], 1'b0};
            ovf_in = ovf_ff | q_ff[63];
            if (remx >= d_ff) begin
               rem_in = remx - d_ff;
               q_in   = {q_ff[62:0], 1'b1};
            end else begin
               rem_in = remx;
               q_in   = {q_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) state_in = DIV_END;
         end
         DIV_END: begin
            res_in   = from_mag(neg_ff, ovf_ff ? '1 : q_ff);
            done_in  = 1'b1;
            state_in = DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         cnt_ff   <= 7'd0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
      res_ff <= res_in;
   end

   assign drsp.done = done_ff;
   assign drsp.res  = res_ff;

endmodule

### sv/newton_root_basin_finder.sv
// operation: a root write is stored on the beat it is accepted; a run takes up to
//   max_iterations newton steps
// concurrency: one run at a time; the shared multi-cycle multiplier and the bit-serial
//   divider set the step time
// reset: synchronous; configuration returns to its defaults, the root memory is undefined
//   until written and has no clearing pass
// ----------------------------------------------------------------------------
// newton_root_basin_finder
// newton iteration over a monic polynomial held as its roots in a small
// memory; reports the first root whose basin the start point falls into
// ----------------------------------------------------------------------------
module newton_root_basin_finder import nrbf_pkg::*; #(
   parameter int unsigned MAX_ROOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // address and loop counter widths
   localparam int unsigned AW = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;
   localparam int unsigned CW = $clog2(MAX_ROOTS + 1);

   // configuration registers
   logic [3:0]  root_count_ff;
   logic [30:0] tolerance_ff;
   logic [9:0]  max_iter_ff;

   // root memory, real part in the upper half of a word
   logic [63:0] root_mem [MAX_ROOTS];
   logic [63:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;

   // sequencer
   ctl_state_type state_ff, state_in;
   logic          pend_ff, pend_in;
   logic [1:0]    k_ff, k_in;
   logic [CW-1:0] j_ff, j_in, oi_ff, oi_in, n_ff, n_in;
   logic [9:0]    iter_ff, iter_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   rsp_type       fin_ff, fin_in;

   // datapath registers
   logic signed [31:0] cur_re_ff, cur_re_in, cur_im_ff, cur_im_in;
   logic signed [63:0] xr_ff, xr_in, xi_ff, xi_in;
   logic signed [63:0] wr_ff, wr_in, wi_ff, wi_in;
   logic signed [63:0] tr_ff, tr_in, ti_ff, ti_in, nre_ff, nre_in, ma_ff, ma_in;
   logic signed [63:0] pr_ff, pr_in, pi_ff, pi_in, dr_ff, dr_in, di_ff, di_in;
   logic signed [63:0] den_ff, den_in, nr_ff, nr_in, ni_ff, ni_in, tol2_ff, tol2_in;

   mul_req_type mreq;
   mul_rsp_type mrsp;
   div_req_type dreq;
   div_rsp_type drsp;
   logic        mul_go, div_go;

   logic signed [63:0] tq, m_sum, m_dif, rd_re_q, rd_im_q;
   logic signed [32:0] dx33, dy33;
   logic               req_beat, skip_j;

   nrbf_qmul u_qmul (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

   nrbf_qdiv u_qdiv (
      .clock (clock),
      .reset (reset),
      .dreq  (dreq),
      .drsp  (drsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // tolerance in q32.32, never negative
   assign tq = {25'd0, tolerance_ff, 8'd0};

   // root entry lifted to q32.32
   assign rd_re_q = {{24{rd_ff[63]}}, rd_ff[63:32], 8'd0};
   assign rd_im_q = {{24{rd_ff[31]}}, rd_ff[31:0], 8'd0};

   // distance from the new point to a root, still q8.24 but 33 bits wide
   assign dx33 = {cur_re_ff[31], cur_re_ff} - {rd_ff[63], rd_ff[63:32]};
   assign dy33 = {cur_im_ff[31], cur_im_ff} - {rd_ff[31], rd_ff[31:0]};

   assign m_sum = sat_add(ma_ff, mrsp.res);
   assign m_dif = sat_sub(ma_ff, mrsp.res);

   // p' terms leave out one root: outer pass zero builds p itself
   assign skip_j  = (oi_ff != '0) && (j_ff == oi_ff - CW'(1));
   assign rd_addr = AW'(j_ff);
   assign mem_we  = req_beat && (req_data.cmd == CMD_ROOT_WRITE)
                    && (32'(req_data.root_index) < 32'(MAX_ROOTS));

   // multiplier operand select
   always_comb begin
      mreq.go = mul_go;
      mreq.a  = tr_ff;
      mreq.b  = wr_ff;
      case (state_ff)
         ST_TOL: begin
            mreq.a = tq;
            mreq.b = tq;
         end
         ST_CMUL: begin
            case (k_ff)
               2'd0:    begin mreq.a = tr_ff; mreq.b = wr_ff; end
               2'd1:    begin mreq.a = ti_ff; mreq.b = wi_ff; end
               2'd2:    begin mreq.a = ti_ff; mreq.b = wr_ff; end
               default: begin mreq.a = tr_ff; mreq.b = wi_ff; end
            endcase
         end
         ST_DEN: begin
            mreq.a = k_ff[0] ? di_ff : dr_ff;
            mreq.b = k_ff[0] ? di_ff : dr_ff;
         end
         ST_NUM: begin
            case (k_ff)
               2'd0:    begin mreq.a = pr_ff; mreq.b = dr_ff; end
               2'd1:    begin mreq.a = pi_ff; mreq.b = di_ff; end
               2'd2:    begin mreq.a = pi_ff; mreq.b = dr_ff; end
               default: begin mreq.a = pr_ff; mreq.b = di_ff; end
            endcase
         end
         ST_CHK: begin
            mreq.a = k_ff[0] ? wi_ff : wr_ff;
            mreq.b = k_ff[0] ? wi_ff : wr_ff;
         end
         default: ;
      endcase
   end

   assign dreq.go  = div_go;
   assign dreq.num = (state_ff == ST_DIVR) ? nr_ff : ni_ff;
   assign dreq.den = den_ff;

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      oi_in        = oi_ff;
      n_in         = n_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      fin_in       = fin_ff;
      cur_re_in    = cur_re_ff;
      cur_im_in    = cur_im_ff;
      xr_in        = xr_ff;
      xi_in        = xi_ff;
      wr_in        = wr_ff;
      wi_in        = wi_ff;
      tr_in        = tr_ff;
      ti_in        = ti_ff;
      nre_in       = nre_ff;
      ma_in        = ma_ff;
      pr_in        = pr_ff;
      pi_in        = pi_ff;
      dr_in        = dr_ff;
      di_in        = di_ff;
      den_in       = den_ff;
      nr_in        = nr_ff;
      ni_in        = ni_ff;
      tol2_in      = tol2_ff;
      mul_go       = 1'b0;
      div_go       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // a root write is done by the memory port on the same beat
            if (req_beat && req_data.cmd == CMD_RUN) begin
               cur_re_in = req_data.start_re;
               cur_im_in = req_data.start_im;
               n_in      = (32'(root_count_ff) > 32'(MAX_ROOTS)) ? CW'(MAX_ROOTS)
                                                                  : CW'(root_count_ff);
               iter_in   = 10'd0;
               state_in  = ST_TOL;
            end
         end
         ST_TOL: begin
            if (!pend_ff) begin
               mul_go  = 1'b1;
               pend_in = 1'b1;
            end else if (mrsp.done) begin
               pend_in = 1'b0;
               tol2_in = mrsp.res;
               if (max_iter_ff == 10'd0) begin
                  fin_in   = '0;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_IT;
               end
            end
         end
         ST_IT: begin
            xr_in    = {{24{cur_re_ff[31]}}, cur_re_ff, 8'd0};
            xi_in    = {{24{cur_im_ff[31]}}, cur_im_ff, 8'd0};
            dr_in    = '0;
            di_in    = '0;
            oi_in    = '0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            tr_in    = Q_ONE;
            ti_in    = '0;
            j_in     = '0;
            state_in = ST_IN;
         end
         ST_IN: begin
            // memory read of root j is in flight when leaving
            if (j_ff == n_ff) state_in = ST_OEND;
            else if (skip_j)  j_in = j_ff + CW'(1);
            else              state_in = ST_WLD;
         end
         ST_WLD: begin
            wr_in    = xr_ff - rd_re_q;
            wi_in    = xi_ff - rd_im_q;
            k_in     = 2'd0;
            state_in = ST_CMUL;
         end
         ST_CMUL: begin
            if (!pend_ff) begin
               mul_go  = 1'b1;
               pend_in = 1'b1;
            end else if (mrsp.done) begin
               pend_in = 1'b0;
               k_in    = k_ff + 2'd1;
               case (k_ff)
                  2'd0: ma_in  = mrsp.res;
                  2'd1: nre_in = m_dif;
                  2'd2: ma_in  = mrsp.res;
                  default: begin
                     ti_in    = m_sum;
                     tr_in    = nre_ff;
                     j_in     = j_ff + CW'(1);
                     state_in = ST_IN;
                  end
               endcase
            end
         end
         ST_OEND: begin
            if (oi_ff == '0) begin
               pr_in = tr_ff;
               pi_in = ti_ff;
            end else begin
               dr_in = sat_add(dr_ff, tr_ff);
               di_in = sat_add(di_ff, ti_ff);
            end
            if (oi_ff == n_ff) begin
               k_in     = 2'd0;
               state_in = ST_DEN;
            end else begin
               oi_in    = oi_ff + CW'(1);
               state_in = ST_OUT;
            end
         end
         ST_DEN: begin
            if (!pend_ff) begin
               mul_go  = 1'b1;
               pend_in = 1'b1;
            end else if (mrsp.done) begin
               pend_in = 1'b0;
               if (k_ff == 2'd0) begin
                  ma_in = mrsp.res;
                  k_in  = 2'd1;
               end else begin
                  den_in = m_sum;
                  k_in   = 2'd0;
                  // zero derivative ends the run
                  if (m_sum <= 64'sd0) begin
                     fin_in   = '0;
                     state_in = ST_FIN;
                  end else begin
                     state_in = ST_NUM;
                  end
               end
            end
         end
         ST_NUM: begin
            if (!pend_ff) begin
               mul_go  = 1'b1;
               pend_in = 1'b1;
            end else if (mrsp.done) begin
               pend_in = 1'b0;
               k_in    = k_ff + 2'd1;
               case (k_ff)
                  2'd0: ma_in = mrsp.res;
                  2'd1: nr_in = m_sum;
                  2'd2: ma_in = mrsp.res;
                  default: begin
                     ni_in    = m_dif;
                     state_in = ST_DIVR;
                  end
               endcase
            end
         end
         ST_DIVR: begin
            if (!pend_ff) begin
               div_go  = 1'b1;
               pend_in = 1'b1;
            end else if (drsp.done) begin
               pend_in   = 1'b0;
               cur_re_in = to_q824(sat_sub(xr_ff, drsp.res));
               state_in  = ST_DIVI;
            end
         end
         ST_DIVI: begin
            if (!pend_ff) begin
               div_go  = 1'b1;
               pend_in = 1'b1;
            end else if (drsp.done) begin
               pend_in   = 1'b0;
               cur_im_in = to_q824(sat_sub(xi_ff, drsp.res));
               iter_in   = iter_ff + 10'd1;
               j_in      = '0;
               state_in  = ST_CRD;
            end
         end
         ST_CRD: begin
            if (j_ff == n_ff) begin
               if (iter_ff == max_iter_ff) begin
                  fin_in   = '0;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_IT;
               end
            end else begin
               state_in = ST_CLD;
            end
         end
         ST_CLD: begin
            wr_in    = {{23{dx33[32]}}, dx33, 8'd0};
            wi_in    = {{23{dy33[32]}}, dy33, 8'd0};
            k_in     = 2'd0;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (!pend_ff) begin
               mul_go  = 1'b1;
               pend_in = 1'b1;
            end else if (mrsp.done) begin
               pend_in = 1'b0;
               if (k_ff == 2'd0) begin
                  ma_in = mrsp.res;
                  k_in  = 2'd1;
               end else if (m_sum < tol2_ff) begin
                  // first root in order within tolerance wins
                  fin_in.found       = 1'b1;
                  fin_in.root_number = 3'(j_ff);
                  state_in           = ST_FIN;
               end else begin
                  j_in     = j_ff + CW'(1);
                  state_in = ST_CRD;
               end
            end
         end
         ST_FIN: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = fin_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff       <= 1'b0;
         k_ff          <= 2'd0;
         j_ff          <= '0;
         oi_ff         <= '0;
         n_ff          <= '0;
         iter_ff       <= 10'd0;
         rsp_valid_ff  <= 1'b0;
         cur_re_ff     <= '0;
         cur_im_ff     <= '0;
         root_count_ff <= ROOT_COUNT_RST;
         tolerance_ff  <= TOLERANCE_RST;
         max_iter_ff   <= MAX_ITER_RST;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         oi_ff        <= oi_in;
         n_ff         <= n_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_re_ff    <= cur_re_in;
         cur_im_ff    <= cur_im_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ROOT_COUNT: root_count_ff <= csr_wdata[3:0];
               CSR_TOLERANCE:  tolerance_ff  <= csr_wdata[30:0];
               CSR_MAX_ITER:   max_iter_ff   <= csr_wdata[9:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      fin_ff  <= fin_in;
      xr_ff   <= xr_in;
      xi_ff   <= xi_in;
      wr_ff   <= wr_in;
      wi_ff   <= wi_in;
      tr_ff   <= tr_in;
      ti_ff   <= ti_in;
      nre_ff  <= nre_in;
      ma_ff   <= ma_in;
      pr_ff   <= pr_in;
      pi_ff   <= pi_in;
      dr_ff   <= dr_in;
      di_ff   <= di_in;
      den_ff  <= den_in;
      nr_ff   <= nr_in;
      ni_ff   <= ni_in;
      tol2_ff <= tol2_in;
   end

   // root memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) root_mem[AW'(req_data.root_index)] <= {req_data.root_re, req_data.root_im};
      rd_ff <= root_mem[rd_addr];
   end

   // a unit answers only to a request still outstanding
   a_done_pending: assert property (@(posedge clock) disable iff (reset)
      (mrsp.done || drsp.done) |-> pend_ff)
      else $error("arithmetic unit answered with no request outstanding");

   // nothing outstanding while new beats are taken
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !pend_ff)
      else $error("arithmetic request still outstanding in idle");

   // a result appears only out of the finish state
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside the finish state");

endmodule
